[src/jebr_pkg.sv]
// Shared types and constants of the JPEG entropy bit reader.
// No dependencies; imported by jpeg_entropy_bit_reader.
package jebr_pkg;

	localparam int unsigned VALUE_W = 16;
	localparam int unsigned HELD_W  = 6;
	localparam int unsigned COUNT_W = 5;
	localparam int unsigned BYTE_W  = 8;

	localparam logic [BYTE_W-1:0] BYTE_FF    = 8'hFF;
	localparam logic [BYTE_W-1:0] BYTE_STUFF = 8'h00;

	// request kind, carried in s_axis_tuser
	typedef enum logic [1:0] {
		REQ_PUSH   = 2'd0,
		REQ_READ   = 2'd1,
		REQ_RESYNC = 2'd2
	} req_t;

	// result status, carried in m_axis_tuser
	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_SHORT = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef struct packed {
		logic [HELD_W-1:0]  bits_held;
		status_t            status;
		logic [VALUE_W-1:0] bits_value;
	} result_t;

endpackage

[src/jpeg_entropy_bit_reader.sv]
// JPEG entropy-coded data bit reader with 0xFF00 unstuffing.
// Depends on jebr_pkg (request/status codes, result record).
// Usage
//   Requests arrive on the s_axis channel: s_axis_tuser selects push byte,
//   read bits or resync; s_axis_tdata carries the byte, the bit count and
//   the signed (EXTEND) flag. Every request gives exactly one result on
//   m_axis: the bits read, a status in m_axis_tuser and the bits left held.
//   Pushed bytes go into a BUFFER_BITS wide bit buffer; a 0x00 directly
//   after an accepted 0xFF is dropped. Reads take up to MAX_READ_BITS bits,
//   most significant first, through one barrel shifter.
// Throughput and registering
//   One request per cycle while s_axis_tready is high. The buffer state is
//   updated at the accepting edge and each result is registered, in the
//   result register or the skid entry. The shift/extend path is combinational.
// Stall
//   A two-entry output stage (result register plus skid register) keeps
//   s_axis_tready registered; while m_axis_tready is low one more request
//   is taken into the skid entry, then s_axis_tready drops.
// Reset
//   arst_n clears the buffer count, the 0xFF flag and both output entries.
module jpeg_entropy_bit_reader #(
	parameter int unsigned BUFFER_BITS   = 32,
	parameter int unsigned MAX_READ_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// [7:0] data_byte, [12:8] read_count, [13] signed_mode, [15:14] zero
	input  logic [15:0] s_axis_tdata,
	// [1:0] req_type
	input  logic [1:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [15:0] bits_value, [21:16] bits_held, [23:22] zero
	output logic [23:0] m_axis_tdata,
	// [1:0] status
	output logic [1:0]  m_axis_tuser
);
	import jebr_pkg::*;

	localparam int unsigned CNT_W = $clog2(BUFFER_BITS + 1);

	// buffer state
	logic [BUFFER_BITS-1:0] buf_q;
	logic [CNT_W-1:0]       count_q;
	logic                   after_ff_q;

	// output stage
	logic    out_valid_q, skid_valid_q;
	result_t out_q, skid_q;

	// request fields
	req_t               req;
	logic [BYTE_W-1:0]  data_byte;
	logic [COUNT_W-1:0] read_count;
	logic               signed_mode;

	assign req         = req_t'(s_axis_tuser);
	assign data_byte   = s_axis_tdata[7:0];
	assign read_count  = s_axis_tdata[12:8];
	assign signed_mode = s_axis_tdata[13];

	logic accept, pop;
	assign s_axis_tready = !skid_valid_q;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign pop           = out_valid_q && m_axis_tready;

	// datapath
	logic [COUNT_W-1:0]     n_sat;
	logic [CNT_W-1:0]       n_ext, rest;
	logic [BUFFER_BITS-1:0] shifted;
	logic [BUFFER_BITS:0]   keep_mask;
	logic [VALUE_W:0]       n_pow;
	logic [VALUE_W-1:0]     raw_val, ext_val;
	logic                   push_full, stuffed, read_short;

	assign n_sat     = (read_count > COUNT_W'(MAX_READ_BITS)) ?
	                   COUNT_W'(MAX_READ_BITS) : read_count;
	assign n_ext     = CNT_W'(n_sat);
	assign rest      = count_q - n_ext;
	assign shifted   = buf_q >> rest;
	assign n_pow     = (VALUE_W+1)'(1) << n_sat;
	assign raw_val   = shifted[VALUE_W-1:0] & VALUE_W'(n_pow - (VALUE_W+1)'(1));
	// EXTEND: values with a clear top bit are negative
	assign ext_val   = VALUE_W'((VALUE_W+1)'(raw_val) - n_pow + (VALUE_W+1)'(1));
	assign keep_mask = ((BUFFER_BITS+1)'(1) << rest) - (BUFFER_BITS+1)'(1);
	assign stuffed   = after_ff_q && (data_byte == BYTE_STUFF);
	assign push_full = ((CNT_W+1)'(count_q) + (CNT_W+1)'(8)) > (CNT_W+1)'(BUFFER_BITS);
	assign read_short = n_ext > count_q;

	logic [BUFFER_BITS-1:0] buf_d;
	logic [CNT_W-1:0]       count_d;
	logic                   after_ff_d;
	result_t                res;

	always_comb begin
		buf_d          = buf_q;
		count_d        = count_q;
		after_ff_d     = after_ff_q;
		res.bits_value = '0;
		res.status     = ST_OK;
		unique case (req)
			REQ_PUSH: begin
				if (stuffed) begin
					after_ff_d = 1'b0;
				end else if (push_full) begin
					res.status = ST_FULL;
				end else begin
					buf_d      = {buf_q[BUFFER_BITS-BYTE_W-1:0], data_byte};
					count_d    = count_q + CNT_W'(8);
					after_ff_d = (data_byte == BYTE_FF);
				end
			end
			REQ_READ: begin
				if (read_short) begin
					res.status = ST_SHORT;
				end else if (n_sat != '0) begin
					if (signed_mode && !raw_val[4'(n_sat - COUNT_W'(1))])
						res.bits_value = ext_val;
					else
						res.bits_value = raw_val;
					count_d = rest;
					buf_d   = buf_q & keep_mask[BUFFER_BITS-1:0];
				end
			end
			REQ_RESYNC: begin
				count_d = count_q & ~CNT_W'(7);
			end
			default: begin
			end
		endcase
		res.bits_held = HELD_W'(count_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			after_ff_q <= 1'b0;
			buf_q      <= '0;
		end else if (accept) begin
			count_q    <= count_d;
			after_ff_q <= after_ff_d;
			buf_q      <= buf_d;
		end
	end

	// result register with skid entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
			out_q        <= '0;
			skid_q       <= '0;
		end else if (skid_valid_q) begin
			if (pop) begin
				out_q        <= skid_q;
				skid_valid_q <= 1'b0;
			end
		end else if (accept) begin
			if (!out_valid_q || pop) begin
				out_q       <= res;
				out_valid_q <= 1'b1;
			end else begin
				skid_q       <= res;
				skid_valid_q <= 1'b1;
			end
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {2'b00, out_q.bits_held, out_q.bits_value};
	assign m_axis_tuser  = out_q.status;

	// checks
	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry held while result register empty");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(BUFFER_BITS))
		else $error("bit count beyond buffer size");

	a_full_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && req == REQ_PUSH && !stuffed && push_full) |=>
		($stable(count_q) && $stable(buf_q)))
		else $error("refused byte changed the buffer");

	a_short_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && req == REQ_READ && read_short) |=> $stable(count_q))
		else $error("short read changed the bit count");

endmodule

[tb/jpeg_entropy_bit_reader_checker.sv]
// Watches the request and result streams of the JPEG entropy bit reader.
// Keeps its own bit buffer model and compares every result in order.
// Depends on jebr_pkg (request/status codes, result record).
`timescale 1ns / 1ps

module jpeg_entropy_bit_reader_checker #(
	parameter int unsigned BUFFER_BITS   = 32,
	parameter int unsigned MAX_READ_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,
	input  logic [1:0]  s_axis_tuser,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [23:0] m_axis_tdata,
	input  logic [1:0]  m_axis_tuser,
	output int          fail_count,
	output int          pending
);
	import jebr_pkg::*;

	logic [BUFFER_BITS-1:0] held_bits;
	int unsigned            held_count;
	bit                     ff_seen;
	result_t                awaited_results[$];
	int                     mismatches = 0;

	// Applies one request to the modelled buffer and gives its result.
	task automatic apply_request(input logic [1:0] kind, input logic [7:0] byte_in,
			input logic [4:0] count_in, input logic sgn, output result_t res);
		int unsigned n;
		int unsigned rest;
		logic [31:0] v;
		res.bits_value = '0;
		res.status     = ST_OK;
		case (kind)
			REQ_PUSH: begin
				if (ff_seen && byte_in == BYTE_STUFF) begin
					ff_seen = 1'b0;
				end else if (held_count + 8 > BUFFER_BITS) begin
					res.status = ST_FULL;
				end else begin
					held_bits  = (held_bits << 8) | byte_in;
					held_count = held_count + 8;
					ff_seen    = (byte_in == BYTE_FF);
				end
			end
			REQ_READ: begin
				n = (count_in > MAX_READ_BITS) ? MAX_READ_BITS : count_in;
				if (n > held_count) begin
					res.status = ST_SHORT;
				end else if (n > 0) begin
					rest = held_count - n;
					v    = 32'(held_bits >> rest) & ((32'd1 << n) - 32'd1);
					// EXTEND: values below half range map to negatives
					if (sgn && v < (32'd1 << (n - 1)))
						v = v - (32'd1 << n) + 32'd1;
					res.bits_value = v[15:0];
					held_count     = rest;
					held_bits      = held_bits & ~({BUFFER_BITS{1'b1}} << rest);
				end
			end
			REQ_RESYNC: begin
				// the bits left over from a part-read byte are the oldest ones
				held_count = held_count - (held_count & 32'd7);
			end
			default: ;
		endcase
		res.bits_held = 6'(held_count);
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		result_t want;
		result_t got;
		if (!arst_n) begin
			held_bits  = '0;
			held_count = 0;
			ff_seen    = 1'b0;
			awaited_results.delete();
			pending    <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got.bits_value = m_axis_tdata[15:0];
				got.bits_held  = m_axis_tdata[21:16];
				got.status     = status_t'(m_axis_tuser);
				if (awaited_results.size() == 0) begin
					$display("%0t: unexpected result, expected none, got value %h status %0d held %0d",
						$time, got.bits_value, got.status, got.bits_held);
					mismatches++;
				end else begin
					want = awaited_results.pop_front();
					if (got.bits_value !== want.bits_value) begin
						$display("%0t: bits_value expected %h, got %h",
							$time, want.bits_value, got.bits_value);
						mismatches++;
					end
					if (got.status !== want.status) begin
						$display("%0t: status expected %0d, got %0d",
							$time, want.status, got.status);
						mismatches++;
					end
					if (got.bits_held !== want.bits_held) begin
						$display("%0t: bits_held expected %0d, got %0d",
							$time, want.bits_held, got.bits_held);
						mismatches++;
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				apply_request(s_axis_tuser, s_axis_tdata[7:0], s_axis_tdata[12:8],
					s_axis_tdata[13], want);
				awaited_results.push_back(want);
			end
			pending <= awaited_results.size();
		end
		fail_count <= mismatches;
	end

endmodule

[tb/jpeg_entropy_bit_reader_tb.sv]
// Top of the JPEG entropy bit reader testbench: clock, reset, request
// stimulus, result back-pressure and verdict.
// Depends on jebr_pkg, jpeg_entropy_bit_reader and its checker.
`timescale 1ns / 1ps

module jpeg_entropy_bit_reader_tb;
	import jebr_pkg::*;

	localparam int unsigned BUFFER_BITS   = 32;
	localparam int unsigned MAX_READ_BITS = 16;
	localparam int unsigned RANDOM_ITEMS  = 1625;
	// spare request code: the block must treat it as a no-op
	localparam logic [1:0]  REQ_SPARE     = 2'd3;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	// [7:0] data_byte, [12:8] read_count, [13] signed_mode, [15:14] zero
	logic [15:0] s_axis_tdata = '0;
	// [1:0] req_type
	logic [1:0]  s_axis_tuser = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	// [15:0] bits_value, [21:16] bits_held, [23:22] zero
	logic [23:0] m_axis_tdata;
	// [1:0] status
	logic [1:0]  m_axis_tuser;

	int fail_count;
	int pending;
	// when set, both sides run without idle gaps
	bit calm = 1'b0;

	always #1 clk = ~clk;

	jpeg_entropy_bit_reader #(
		.BUFFER_BITS  (BUFFER_BITS),
		.MAX_READ_BITS(MAX_READ_BITS)
	) u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

	jpeg_entropy_bit_reader_checker #(
		.BUFFER_BITS  (BUFFER_BITS),
		.MAX_READ_BITS(MAX_READ_BITS)
	) u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.fail_count   (fail_count),
		.pending      (pending)
	);

	// Offers one request and returns at the edge that accepts it.
	// With drain set the sender first holds off until every result is back.
	task automatic send_request(input logic [1:0] kind, input logic [7:0] byte_in,
			input logic [4:0] count_in, input bit sgn, input bit drain);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 3);
		if (drain || gap != 0)
			s_axis_tvalid <= 1'b0;
		if (drain) begin
			@(posedge clk);
			while (pending != 0)
				@(posedge clk);
		end
		repeat (gap) @(posedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= kind;
		s_axis_tdata  <= {2'b00, sgn, count_in, byte_in};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
	endtask

	// Result side: a random stall before each result, none in calm stretches.
	initial begin : result_sink
		int stall;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			stall = calm ? 0 : $urandom_range(0, 3);
			if (stall != 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			@(posedge clk);
			while (!m_axis_tvalid)
				@(posedge clk);
		end
	end

	initial begin : stimulus
		int       pick;
		bit       last_was_ff;
		bit       hold;
		logic [7:0] b;
		logic [4:0] cnt;
		last_was_ff = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty buffer corners and the spare code
		send_request(REQ_READ,   8'h00, 5'd0,  1'b1, 1'b0); // zero count, signed
		send_request(REQ_READ,   8'h00, 5'd1,  1'b0, 1'b0); // too few bits
		send_request(REQ_RESYNC, 8'h00, 5'd0,  1'b0, 1'b0);
		send_request(REQ_SPARE,  8'hFF, 5'd31, 1'b1, 1'b0);
		// stuffing, repeated 0xFF, a real 0x00 and a refused byte
		send_request(REQ_PUSH,   BYTE_FF,    5'd0, 1'b0, 1'b0);
		send_request(REQ_PUSH,   BYTE_STUFF, 5'd0, 1'b0, 1'b0); // dropped
		send_request(REQ_PUSH,   BYTE_FF,    5'd0, 1'b0, 1'b0);
		send_request(REQ_PUSH,   BYTE_FF,    5'd0, 1'b0, 1'b0);
		send_request(REQ_PUSH,   BYTE_STUFF, 5'd0, 1'b0, 1'b0); // dropped
		send_request(REQ_PUSH,   BYTE_STUFF, 5'd0, 1'b0, 1'b0); // kept, buffer now full
		send_request(REQ_PUSH,   8'hA5,      5'd0, 1'b0, 1'b0); // refused
		// oversize count saturates, then short signed reads and a resync
		send_request(REQ_READ,   8'h00, 5'd31, 1'b0, 1'b0);
		send_request(REQ_READ,   8'h00, 5'd1,  1'b1, 1'b0);
		send_request(REQ_READ,   8'h00, 5'd3,  1'b1, 1'b0);
		send_request(REQ_RESYNC, 8'h00, 5'd0,  1'b0, 1'b0);
		send_request(REQ_READ,   8'h00, 5'd9,  1'b1, 1'b0);
		send_request(REQ_READ,   8'h00, 5'd8,  1'b1, 1'b0); // all zero, most negative
		// full buffer ending in 0xFF: stuffing needs no room, others refused
		send_request(REQ_PUSH,   8'h12,      5'd0, 1'b0, 1'b0);
		send_request(REQ_PUSH,   8'h34,      5'd0, 1'b0, 1'b0);
		send_request(REQ_PUSH,   8'h56,      5'd0, 1'b0, 1'b0);
		send_request(REQ_PUSH,   BYTE_FF,    5'd0, 1'b0, 1'b0);
		send_request(REQ_PUSH,   BYTE_STUFF, 5'd0, 1'b0, 1'b0);
		send_request(REQ_PUSH,   BYTE_STUFF, 5'd0, 1'b0, 1'b0);
		send_request(REQ_READ,   8'h00, 5'd16, 1'b1, 1'b0);
		send_request(REQ_READ,   8'h00, 5'd1,  1'b1, 1'b0);
		send_request(REQ_READ,   8'h00, 5'd15, 1'b0, 1'b0);

		// random: pushes and reads roughly balance, so the buffer wanders
		// between empty and full and both refusal paths keep turning up
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			calm = (i % 300) < 60;
			hold = (i == RANDOM_ITEMS / 2);
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				if (last_was_ff && $urandom_range(0, 1))
					b = BYTE_STUFF;
				else begin
					case ($urandom_range(0, 9))
						0, 1:    b = BYTE_FF;
						2:       b = BYTE_STUFF;
						default: b = 8'($urandom_range(0, 255));
					endcase
				end
				last_was_ff = (b == BYTE_FF);
				send_request(REQ_PUSH, b, 5'($urandom_range(0, 31)),
					1'($urandom_range(0, 1)), hold);
			end else if (pick < 90) begin
				cnt = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(17, 31))
					: 5'($urandom_range(0, 16));
				send_request(REQ_READ, 8'($urandom_range(0, 255)), cnt,
					1'($urandom_range(0, 1)), hold);
			end else if (pick < 97) begin
				send_request(REQ_RESYNC, 8'($urandom_range(0, 255)),
					5'($urandom_range(0, 31)), 1'($urandom_range(0, 1)), hold);
			end else begin
				send_request(REQ_SPARE, 8'($urandom_range(0, 255)),
					5'($urandom_range(0, 31)), 1'($urandom_range(0, 1)), hold);
			end
		end
		s_axis_tvalid <= 1'b0;

		// the count seen here is registered in the checker, so let the last request land first
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// watchdog, far beyond the slowest legal run
	initial begin : watchdog
		#400000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

[files.f]
src/jebr_pkg.sv
src/jpeg_entropy_bit_reader.sv
tb/jpeg_entropy_bit_reader_checker.sv
tb/jpeg_entropy_bit_reader_tb.sv
